// ----- design/pefs_pkg.sv -----
// ----------------------------------------------------------------------------
// pefs_pkg: shared definitions for the page extent free stack
// Operation, status and cell command codes, field widths and parameter
// defaults.
// ----------------------------------------------------------------------------
package pefs_pkg;

    // Field widths fixed by the interface
    localparam int OP_W       = 2;
    localparam int PAGE_NUM_W = 40;
    localparam int LEN_W      = 40;
    localparam int TOTAL_W    = 41;
    localparam int STATUS_W   = 2;

    // Parameter defaults
    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_FRAME_BITS  = 40;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_REQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

    // Per-cell command
    typedef logic [1:0] t_cell_cmd;
    localparam t_cell_cmd CMD_HOLD = 2'd0;
    localparam t_cell_cmd CMD_PUSH = 2'd1;
    localparam t_cell_cmd CMD_POP  = 2'd2;
    localparam t_cell_cmd CMD_ADV  = 2'd3;

endpackage

// ----- design/pefs_cell.sv -----
// ----------------------------------------------------------------------------
// pefs_cell: one stack slot
// Holds one extent and loads from its upper or lower neighbor on push or
// pop; the top slot also advances its own extent by one page.
// ----------------------------------------------------------------------------
module pefs_cell
    import pefs_pkg::*;
#(
    parameter int FRAME_BITS = DEF_FRAME_BITS
) (
    input  logic                  i_clk,
    input  t_cell_cmd             i_cmd,
    input  logic [FRAME_BITS-1:0] i_up_base,
    input  logic [LEN_W-1:0]      i_up_len,
    input  logic [FRAME_BITS-1:0] i_dn_base,
    input  logic [LEN_W-1:0]      i_dn_len,
    output logic [FRAME_BITS-1:0] o_base,
    output logic [LEN_W-1:0]      o_len
);

    logic [FRAME_BITS-1:0] r_base;
    logic [LEN_W-1:0]      r_len;
    logic [FRAME_BITS-1:0] n_base;
    logic [LEN_W-1:0]      n_len;

    always_comb begin
        unique case (i_cmd)
            CMD_PUSH: begin
                n_base = i_up_base;
                n_len  = i_up_len;
            end
            CMD_POP: begin
                n_base = i_dn_base;
                n_len  = i_dn_len;
            end
            CMD_ADV: begin
                // base wraps at the frame width
                n_base = r_base + FRAME_BITS'(1);
                n_len  = r_len - LEN_W'(1);
            end
            default: begin
                n_base = r_base;
                n_len  = r_len;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_len  <= n_len;
    end

    assign o_base = r_base;
    assign o_len  = r_len;

endmodule

// ----- design/pefs_cell_row.sv -----
// ----------------------------------------------------------------------------
// pefs_cell_row: shifting extent stack
// A row of cells with the top of stack in cell 0; push shifts the row down,
// pop shifts it up.
// ----------------------------------------------------------------------------
module pefs_cell_row
    import pefs_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int FRAME_BITS  = DEF_FRAME_BITS
) (
    input  logic                  i_clk,
    input  t_cell_cmd             i_cmd,
    input  logic [FRAME_BITS-1:0] i_push_base,
    input  logic [LEN_W-1:0]      i_push_len,
    output logic [FRAME_BITS-1:0] o_top_base,
    output logic [LEN_W-1:0]      o_top_len
);

    logic [FRAME_BITS-1:0] w_base [STACK_DEPTH];
    logic [LEN_W-1:0]      w_len  [STACK_DEPTH];

    // Only the top cell advances; the rest hold meanwhile
    t_cell_cmd w_lower_cmd;
    assign w_lower_cmd = (i_cmd == CMD_ADV) ? CMD_HOLD : i_cmd;

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [FRAME_BITS-1:0] w_up_base;
        logic [LEN_W-1:0]      w_up_len;
        logic [FRAME_BITS-1:0] w_dn_base;
        logic [LEN_W-1:0]      w_dn_len;
        t_cell_cmd             w_cmd;

        if (g == 0) begin : g_top
            assign w_up_base = i_push_base;
            assign w_up_len  = i_push_len;
            assign w_cmd     = i_cmd;
        end else begin : g_mid
            assign w_up_base = w_base[g-1];
            assign w_up_len  = w_len[g-1];
            assign w_cmd     = w_lower_cmd;
        end

        if (g == STACK_DEPTH - 1) begin : g_bottom
            // bottom slot holds on pop; its content is dead then
            assign w_dn_base = w_base[g];
            assign w_dn_len  = w_len[g];
        end else begin : g_inner
            assign w_dn_base = w_base[g+1];
            assign w_dn_len  = w_len[g+1];
        end

        pefs_cell #(
            .FRAME_BITS(FRAME_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (w_cmd),
            .i_up_base (w_up_base),
            .i_up_len  (w_up_len),
            .i_dn_base (w_dn_base),
            .i_dn_len  (w_dn_len),
            .o_base    (w_base[g]),
            .o_len     (w_len[g])
        );
    end

    assign o_top_base = w_base[0];
    assign o_top_len  = w_len[0];

endmodule

// ----- design/page_extent_free_stack_core.sv -----
// ----------------------------------------------------------------------------
// page_extent_free_stack_core: LIFO free-extent page allocator
// Keeps free memory as a stack of (base frame, length) extents, takes in
// whole regions and hands out or takes back one page per transfer.
// ----------------------------------------------------------------------------
// Usage: the block takes one item per clock cycle. An item updates the stack
// in the cycle it is accepted and its result appears in the output register
// on the next cycle; a new item is taken whenever that register is empty or
// is being drained in the same cycle. The stack is a row of STACK_DEPTH
// cells with the top extent in the first cell, so push, pop and the advance
// of the top extent are all registered shifts and the next item always
// sees the updated top. Add (op 0) pushes a usable, non-empty region; request
// (op 1) takes the base frame of the top extent, popping it when its last
// page goes; free (op 2) pushes a one-page extent, and frame 0 is ignored.
// Add or free on a full stack returns status 2 and changes nothing. The free
// page total saturates at its maximum and is not lowered below zero. Stack
// contents need no clearing after reset: only entries below the fill count
// are ever read.
// ----------------------------------------------------------------------------
module page_extent_free_stack_core
    import pefs_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int FRAME_BITS  = DEF_FRAME_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [OP_W-1:0]       i_op,
    input  logic [PAGE_NUM_W-1:0] i_page_number,
    input  logic [LEN_W-1:0]      i_page_count,
    input  logic                  i_region_usable,
    // result output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [PAGE_NUM_W-1:0] o_granted_page,
    output logic [TOTAL_W-1:0]    o_free_pages
);

    localparam int FILL_W = $clog2(STACK_DEPTH + 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [FILL_W-1:0]     r_fill;
    logic [TOTAL_W-1:0]    r_total;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_status;
    logic [PAGE_NUM_W-1:0] r_granted;

    logic [FILL_W-1:0]     n_fill;
    logic [TOTAL_W-1:0]    n_total;

    // ------------------------------------------------------------------
    // Frame width adaptation between the 40-bit ports and FRAME_BITS
    // ------------------------------------------------------------------
    logic [FRAME_BITS-1:0] w_frame;
    logic [FRAME_BITS-1:0] w_top_base;
    logic [PAGE_NUM_W-1:0] w_top_base_out;
    logic [LEN_W-1:0]      w_top_len;

    if (FRAME_BITS > PAGE_NUM_W) begin : g_wide_frame
        assign w_frame        = {{(FRAME_BITS-PAGE_NUM_W){1'b0}}, i_page_number};
        assign w_top_base_out = w_top_base[PAGE_NUM_W-1:0];
    end else if (FRAME_BITS == PAGE_NUM_W) begin : g_same_frame
        assign w_frame        = i_page_number;
        assign w_top_base_out = w_top_base;
    end else begin : g_narrow_frame
        // drop frame bits above FRAME_BITS, zero-extend on the way out
        assign w_frame        = i_page_number[FRAME_BITS-1:0];
        assign w_top_base_out = {{(PAGE_NUM_W-FRAME_BITS){1'b0}}, w_top_base};
    end

    // ------------------------------------------------------------------
    // Handshake: accept whenever the result register can be refilled
    // ------------------------------------------------------------------
    logic w_accept;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Item decode
    // ------------------------------------------------------------------
    logic                  w_full;
    logic                  w_empty;
    logic [STATUS_W-1:0]   w_status;
    logic [PAGE_NUM_W-1:0] w_granted;
    t_cell_cmd             w_cmd;
    logic [LEN_W-1:0]      w_push_len;
    logic                  w_add;
    logic                  w_dec;
    logic [LEN_W-1:0]      w_add_amt;

    assign w_full  = (r_fill == FILL_W'(STACK_DEPTH));
    assign w_empty = (r_fill == '0);

    always_comb begin
        w_status   = ST_IGNORED;
        w_granted  = '0;
        w_cmd      = CMD_HOLD;
        w_push_len = i_page_count;
        w_add      = 1'b0;
        w_dec      = 1'b0;
        w_add_amt  = i_page_count;
        n_fill     = r_fill;
        unique case (i_op)
            OP_ADD: begin
                if (i_region_usable && (i_page_count != '0)) begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_status = ST_OK;
                        w_cmd    = CMD_PUSH;
                        w_add    = 1'b1;
                        n_fill   = r_fill + FILL_W'(1);
                    end
                end
            end
            OP_REQ: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_status  = ST_OK;
                    w_granted = w_top_base_out;
                    w_dec     = 1'b1;
                    // last page of the top extent: pop it, else advance it
                    if (w_top_len <= LEN_W'(1)) begin
                        w_cmd  = CMD_POP;
                        n_fill = r_fill - FILL_W'(1);
                    end else begin
                        w_cmd = CMD_ADV;
                    end
                end
            end
            OP_FREE: begin
                if (w_frame != '0) begin
                    w_push_len = LEN_W'(1);
                    w_add_amt  = LEN_W'(1);
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_status = ST_OK;
                        w_cmd    = CMD_PUSH;
                        w_add    = 1'b1;
                        n_fill   = r_fill + FILL_W'(1);
                    end
                end
            end
            default: begin
                w_status = ST_IGNORED;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Free page counter: saturate on add, stop at zero on take
    // ------------------------------------------------------------------
    logic [TOTAL_W:0] w_sum;
    assign w_sum = {1'b0, r_total} + (TOTAL_W+1)'(w_add_amt);

    always_comb begin
        n_total = r_total;
        if (w_add) begin
            n_total = w_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : w_sum[TOTAL_W-1:0];
        end else if (w_dec && (r_total != '0)) begin
            n_total = r_total - TOTAL_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Extent stack
    // ------------------------------------------------------------------
    t_cell_cmd w_row_cmd;
    assign w_row_cmd = w_accept ? w_cmd : CMD_HOLD;

    pefs_cell_row #(
        .STACK_DEPTH(STACK_DEPTH),
        .FRAME_BITS (FRAME_BITS)
    ) u_row (
        .i_clk       (i_clk),
        .i_cmd       (w_row_cmd),
        .i_push_base (w_frame),
        .i_push_len  (w_push_len),
        .o_top_base  (w_top_base),
        .o_top_len   (w_top_len)
    );

    // ------------------------------------------------------------------
    // Control state and result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill      <= n_fill;
                r_total     <= n_total;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= w_status;
            r_granted <= w_granted;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_granted_page = r_granted;
    assign o_free_pages   = r_total;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(STACK_DEPTH))
        else $error("fill count beyond stack depth");

    a_req_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == OP_REQ) && !w_empty) |=> (o_status == ST_OK))
        else $error("request on non-empty stack not granted");

    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_granted_page == '0))
        else $error("granted page set on a failed item");

    a_free_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == OP_FREE) && (w_frame != '0) && !w_full)
        |=> (r_fill == $past(r_fill) + FILL_W'(1)))
        else $error("free did not push an extent");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && (i_op != OP_REQ)) |=> $stable(r_fill))
        else $error("full stack changed on add or free");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for page_extent_free_stack_core
// Drives add-region, request and free transfers with random idle bursts on
// both channels. A shadow copy of the extent stack and the free page counter
// predicts every result, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_top
    import pefs_pkg::*;
();

    // op 3 is not a defined operation; the block must ignore it
    localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

    localparam logic [PAGE_NUM_W-1:0] FRAME_MAX = {PAGE_NUM_W{1'b1}};
    localparam logic [LEN_W-1:0]      LEN_MAX   = {LEN_W{1'b1}};
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX = {TOTAL_W{1'b1}};

    // Longest receiver hold-off; the watchdog limit sits well above it
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [PAGE_NUM_W-1:0] frame;
        logic [LEN_W-1:0]      pages;
        logic                  usable;
    } t_page_op;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [PAGE_NUM_W-1:0] granted;
        logic [TOTAL_W-1:0]    free_pages;
    } t_alloc_result;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------------
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       op            = OP_ADD;
    logic [PAGE_NUM_W-1:0] page_number   = '0;
    logic [LEN_W-1:0]      page_count    = '0;
    logic                  region_usable = 1'b0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    logic [STATUS_W-1:0]   out_status;
    logic [PAGE_NUM_W-1:0] out_granted;
    logic [TOTAL_W-1:0]    out_free;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    page_extent_free_stack_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_op            (op),
        .i_page_number   (page_number),
        .i_page_count    (page_count),
        .i_region_usable (region_usable),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_status        (out_status),
        .o_granted_page  (out_granted),
        .o_free_pages    (out_free)
    );

    // ------------------------------------------------------------------------
    // Shadow allocator: extent stack, fill count and saturating page total.
    // Updated once per accepted input transfer.
    // ------------------------------------------------------------------------
    logic [PAGE_NUM_W-1:0] shadow_base [DEF_STACK_DEPTH];
    logic [LEN_W-1:0]      shadow_len  [DEF_STACK_DEPTH];
    int                    shadow_fill  = 0;
    logic [TOTAL_W-1:0]    shadow_total = '0;

    t_page_op      queued_ops[$];       // transfers waiting for the driver
    t_alloc_result alloc_outcomes[$];   // predicted results, oldest first

    int  mismatches   = 0;
    logic in_took     = 1'b0;  // input transfer happened at the last rising edge
    bit  quiet        = 1'b0;  // suppress idle bursts on both sides
    int  hold_orders  = 0;     // long receiver hold-offs requested
    int  holds_served = 0;

    // Push an extent; a full stack rejects it and leaves everything as is.
    function automatic logic [STATUS_W-1:0] stack_push(logic [PAGE_NUM_W-1:0] base,
                                                       logic [LEN_W-1:0] len);
        logic [TOTAL_W:0] sum;
        if (shadow_fill >= DEF_STACK_DEPTH)
            return ST_FULL;
        shadow_base[shadow_fill] = base;
        shadow_len[shadow_fill]  = len;
        shadow_fill++;
        // Saturate the running total instead of wrapping
        sum = {1'b0, shadow_total} + len;
        shadow_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        return ST_OK;
    endfunction

    function automatic t_alloc_result apply_page_op(t_page_op req);
        t_alloc_result res;
        int top;
        res.status  = ST_IGNORED;
        res.granted = '0;
        case (req.op)
            OP_ADD: begin
                // Unusable or empty regions are dropped
                if (req.usable && req.pages != '0)
                    res.status = stack_push(req.frame, req.pages);
            end
            OP_REQ: begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    top = shadow_fill - 1;
                    res.granted = shadow_base[top];
                    // Pop on the last page, else advance the base (wraps) and shrink
                    if (shadow_len[top] <= 1) begin
                        shadow_fill--;
                    end else begin
                        shadow_base[top] = shadow_base[top] + 1'b1;
                        shadow_len[top]  = shadow_len[top] - 1'b1;
                    end
                    if (shadow_total != '0)
                        shadow_total = shadow_total - 1'b1;
                    res.status = ST_OK;
                end
            end
            OP_FREE: begin
                // Frame zero is never handed back
                if (req.frame != '0)
                    res.status = stack_push(req.frame, LEN_W'(1));
            end
            default: ;
        endcase
        res.free_pages = shadow_total;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Random transfer generation
    // ------------------------------------------------------------------------
    // Frames: some zero, some at the top of the range to hit the wrap, rest random
    function automatic logic [PAGE_NUM_W-1:0] any_frame();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(11, 0))
            0:       return '0;
            1:       return FRAME_MAX - raw[1:0];
            default: return raw[PAGE_NUM_W-1:0];
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] wide_count();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if ($urandom_range(9, 0) == 0)
            return LEN_MAX;
        return raw[LEN_W-1:0];
    endfunction

    // add_w and req_w are percentages; free takes the rest up to 97, op 3 the tail.
    // Usable adds stay short unless wide is set, so the stack can still drain.
    function automatic t_page_op make_page_op(int add_w, int req_w, bit wide);
        t_page_op req;
        int pick;
        pick       = $urandom_range(99, 0);
        req.frame  = any_frame();
        req.pages  = wide_count();
        req.usable = 1'($urandom_range(1, 0));
        if (pick < add_w) begin
            req.op     = OP_ADD;
            req.usable = ($urandom_range(9, 0) != 0);
            if (req.usable && !(wide && $urandom_range(1, 0) == 0))
                req.pages = ($urandom_range(9, 0) == 0) ? '0 : LEN_W'($urandom_range(3, 1));
        end else if (pick < add_w + req_w) begin
            req.op = OP_REQ;
        end else if (pick < 97) begin
            req.op = OP_FREE;
        end else begin
            req.op = OP_UNDEF;
        end
        return req;
    endfunction

    task automatic queue_op(logic [OP_W-1:0] code, logic [PAGE_NUM_W-1:0] frame,
                            logic [LEN_W-1:0] pages, logic usable);
        queued_ops.push_back({code, frame, pages, usable});
    endtask

    task automatic queue_random(int n, int add_w, int req_w, bit wide);
        repeat (n) queued_ops.push_back(make_page_op(add_w, req_w, wide));
    endtask

    // Hold the sender until every queued transfer is in and every result is out
    task automatic wait_all_settled();
        while (queued_ops.size() != 0 || in_valid || alloc_outcomes.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present one transfer at a time on the falling edge. Hold the
    // payload until accepted, and insert random idle bursts.
    // ------------------------------------------------------------------------
    int       send_gap = 0;
    t_page_op next_op;

    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_took) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (queued_ops.size() != 0 && !quiet
                             && $urandom_range(9, 0) == 0) begin
                    // this cycle counts as the first idle one of the burst
                    send_gap <= $urandom_range(2, 0);
                    in_valid <= 1'b0;
                end else if (queued_ops.size() != 0) begin
                    next_op       = queued_ops.pop_front();
                    in_valid      <= 1'b1;
                    op            <= next_op.op;
                    page_number   <= next_op.frame;
                    page_count    <= next_op.pages;
                    region_usable <= next_op.usable;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure bursts, plus long hold-offs on request
    // so the output register fills and the input stalls.
    // ------------------------------------------------------------------------
    int hold_left = 0;
    int rx_gap    = 0;

    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (hold_orders != holds_served) begin
                hold_left    <= LONG_HOLD - 1;
                holds_served <= holds_served + 1;
                out_ready    <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap    <= rx_gap - 1;
                out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(7, 0) == 0) begin
                rx_gap    <= $urandom_range(2, 0);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: on each rising edge check an output transfer against the oldest
    // prediction, then predict the input transfer taken at this edge. Its
    // result cannot appear before the next edge.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_alloc_result want;
        in_took <= in_valid && in_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (alloc_outcomes.size() == 0) begin
                    mismatches++;
                    $display({"%0t: unexpected result: expected none, ",
                              "actual status %0d granted %h free %h"},
                             $time, out_status, out_granted, out_free);
                end else begin
                    want = alloc_outcomes.pop_front();
                    if (out_status !== want.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, out_status);
                    end
                    if (out_granted !== want.granted) begin
                        mismatches++;
                        $display("%0t: granted_page expected %h, actual %h",
                                 $time, want.granted, out_granted);
                    end
                    if (out_free !== want.free_pages) begin
                        mismatches++;
                        $display("%0t: free_pages expected %h, actual %h",
                                 $time, want.free_pages, out_free);
                    end
                end
            end
            if (in_valid && in_ready)
                alloc_outcomes.push_back(apply_page_op({op, page_number, page_count,
                                                        region_usable}));
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no transfer moves for too long
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("page_extent_free_stack_core verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        longint pages_left;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corner cases from a clean stack
        queue_op(OP_REQ,   '0,          '0,      1'b1);  // empty stack
        queue_op(OP_ADD,   40'd7,       40'd5,   1'b0);  // unusable region
        queue_op(OP_ADD,   40'd9,       '0,      1'b1);  // empty region
        queue_op(OP_FREE,  '0,          40'd1,   1'b1);  // free of frame zero
        queue_op(OP_UNDEF, FRAME_MAX,   LEN_MAX, 1'b1);  // undefined op
        queue_op(OP_ADD,   FRAME_MAX,   40'd3,   1'b1);  // base wraps on advance
        queue_op(OP_REQ,   '0,          '0,      1'b0);
        queue_op(OP_REQ,   '0,          '0,      1'b0);
        queue_op(OP_REQ,   '0,          '0,      1'b0);  // last page pops
        queue_op(OP_REQ,   '0,          '0,      1'b0);  // empty again
        queue_op(OP_FREE,  FRAME_MAX,   LEN_MAX, 1'b0);
        queue_op(OP_FREE,  40'd1,       '0,      1'b0);
        queue_op(OP_REQ,   FRAME_MAX,   '0,      1'b1);  // LIFO: frame 1 first
        queue_op(OP_REQ,   '0,          '0,      1'b1);
        queue_op(OP_ADD,   '0,          40'd1,   1'b1);  // frame zero is fine in add
        queue_op(OP_REQ,   '0,          '0,      1'b0);
        wait_all_settled();

        // Random: alternate fill and drain so full and empty stacks both occur
        queue_random(200, 40, 20, 1'b0);
        wait_all_settled();
        queue_random(250,  5, 88, 1'b0);
        wait_all_settled();

        // Long receiver stall while the sender keeps offering
        queue_random(250, 30, 35, 1'b0);
        @(posedge clk);
        hold_orders++;
        wait_all_settled();

        queue_random(200, 40, 20, 1'b0);
        wait_all_settled();
        queue_random(200, 30, 35, 1'b0);
        wait_all_settled();
        queue_random(250,  5, 88, 1'b0);
        wait_all_settled();

        // Drain the stack completely so the saturation case starts from empty
        pages_left = 0;
        for (int k = 0; k < shadow_fill; k++)
            pages_left += shadow_len[k];
        repeat (pages_left + 1) queue_op(OP_REQ, any_frame(), wide_count(), 1'b1);
        wait_all_settled();

        // Last stretch without idling: drive the page total into saturation,
        // then random traffic with full-range region lengths
        quiet = 1'b1;
        queue_op(OP_ADD,  '0,            LEN_MAX, 1'b1);
        queue_op(OP_ADD,  40'h5555555555, LEN_MAX, 1'b1);
        queue_op(OP_ADD,  40'hAAAAAAAAAA, LEN_MAX, 1'b1);  // total saturates
        queue_op(OP_FREE, 40'h123,        '0,      1'b1);  // stays saturated
        queue_op(OP_REQ,  '0,             '0,      1'b0);
        queue_op(OP_REQ,  '0,             '0,      1'b0);
        queue_op(OP_REQ,  '0,             '0,      1'b0);
        queue_random(150, 30, 35, 1'b1);
        wait_all_settled();

        // Allow time for any stray result to show up
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("page_extent_free_stack_core verification clean");
        else
            $display("page_extent_free_stack_core verification failed");
        $finish;
    end

endmodule
